@@ design/bhp_pkg.sv @@
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types, constants and helpers for the bracketed hex byte parser.
// ----------------------------------------------------------------------------
package bhp_pkg;

  // longest message, address byte included
  localparam int MAX_MESSAGE_BYTES = 64;
  localparam int IDX_W             = $clog2(MAX_MESSAGE_BYTES + 1);

  localparam int CHAR_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 6;
  localparam int EVENT_W = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;  // ']'
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;  // 'f'

  typedef enum logic [EVENT_W-1:0] {
    EV_REJECT = 3'd0,
    EV_ECHO   = 3'd1,
    EV_ADDR   = 3'd2,
    EV_DATA   = 3'd3,
    EV_END    = 3'd4,
    EV_OVER   = 3'd5,
    EV_CLEAR  = 3'd6
  } event_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              clear;
  } item_t;

  typedef struct packed {
    event_t            event_res;
    logic [BYTE_W-1:0] byte_value;
    logic [POS_W-1:0]  byte_position;
    logic [CNT_W-1:0]  data_count;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  // lowercase hex digit decode
  function automatic nibble_t hex_nibble(input logic [CHAR_W-1:0] c);
    nibble_t n;
    n.ok    = 1'b0;
    n.value = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n.ok    = 1'b1;
      n.value = 4'(c - CH_ZERO);
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      n.ok    = 1'b1;
      n.value = 4'(c - CH_LOW_A + 8'd10);
    end
    return n;
  endfunction

endpackage

@@ design/bhp_core.sv @@
// ----------------------------------------------------------------------------
// bhp_core
// Parse state and next-state logic; updates state on each advanced beat.
// ----------------------------------------------------------------------------
module bhp_core import bhp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_SEP  = 2'd3
  } phase_t;

  phase_t           phase, phase_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  nibble_t          nib;

  assign nib = hex_nibble(item.char_code);

  always_comb begin
    phase_next           = phase;
    high_nibble_next     = high_nibble;
    byte_index_next      = byte_index;
    res.event_res        = EV_REJECT;
    res.byte_value       = '0;
    res.byte_position    = '0;
    res.data_count       = '0;
    if (item.clear) begin
      phase_next      = PH_IDLE;
      byte_index_next = '0;
      res.event_res   = EV_CLEAR;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (item.char_code == CH_OPEN) begin
            phase_next    = PH_HIGH;
            res.event_res = EV_ECHO;
          end
        end
        PH_HIGH, PH_LOW: begin
          if (!nib.ok) begin
            res.event_res = EV_REJECT;
          end else if (byte_index >= IDX_W'(MAX_MESSAGE_BYTES)) begin
            phase_next      = PH_IDLE;
            byte_index_next = '0;
            res.event_res   = EV_OVER;
          end else if (phase == PH_HIGH) begin
            high_nibble_next = nib.value;
            phase_next       = PH_LOW;
            res.event_res    = EV_ECHO;
          end else begin
            phase_next        = PH_SEP;
            byte_index_next   = byte_index + IDX_W'(1);
            res.event_res     = (byte_index == '0) ? EV_ADDR : EV_DATA;
            res.byte_value    = {high_nibble, nib.value};
            res.byte_position = POS_W'(byte_index);
          end
        end
        PH_SEP: begin
          if (item.char_code == CH_SPACE) begin
            phase_next    = PH_HIGH;
            res.event_res = EV_ECHO;
          end else if (item.char_code == CH_CLOSE) begin
            phase_next      = PH_IDLE;
            byte_index_next = '0;
            res.event_res   = EV_END;
            // address byte is not counted as data
            res.data_count  = (byte_index == '0) ? '0 : CNT_W'(byte_index - IDX_W'(1));
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
      byte_index  <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      byte_index  <= byte_index_next;
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (phase == PH_IDLE && byte_index == '0))
    else $error("parser not idle after reset");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(MAX_MESSAGE_BYTES))
    else $error("byte index past message limit");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && item.clear) |=> (phase == PH_IDLE && byte_index == '0))
    else $error("clear did not return parser to idle");

  a_byte_from_low: assert property (@(posedge clk) disable iff (rst)
    (fire && (res.event_res == EV_ADDR || res.event_res == EV_DATA))
      |=> (phase == PH_SEP && byte_index == $past(byte_index) + IDX_W'(1)))
    else $error("byte completed without entering separator phase");

endmodule

@@ design/bracketed_hex_byte_parser_unit.sv @@
// ----------------------------------------------------------------------------
// bracketed_hex_byte_parser_unit
// Parses "[xx xx ...]" lowercase hex messages, one character per beat.
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   char_code[7:0]                          clear
//   m_axis   out  byte_value[7:0] byte_position[13:8]     event_res[2:0]
//                 data_count[19:14], zero pad [23:20]
//
// one beat in gives one beat out; a beat is accepted every cycle while m_axis does not stall
// a beat goes through the input register, then parse logic into the result register
// the result register frees as the sink takes it, so input keeps flowing
// under m_axis stalls until both registers hold a beat
// rst is synchronous and returns the parser to idle with an empty pipe
// ----------------------------------------------------------------------------
module bracketed_hex_byte_parser_unit import bhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // char_code
  input  logic                  s_axis_tuser,   // clear
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // byte_value, byte_position, data_count
  output logic [EVENT_W-1:0]    m_axis_tuser    // event_res
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.char_code <= s_axis_tdata;
      in_item.clear     <= s_axis_tuser;
    end
  end

  bhp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.event_res;
  assign m_axis_tdata  = {4'd0, out_res.data_count, out_res.byte_position,
                          out_res.byte_value};

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the hex message parser with a short directed run and then random
// messages, clears and noise. The sender works in bursts and the sink stalls
// at random. A scoreboard predicts one result beat for every character beat
// and checks the results in order.
// ----------------------------------------------------------------------------
module testbench;
  import bhp_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 12;
  localparam int ITEM_GOAL  = 1250;
  localparam int CYCLE_CAP  = 200000;
  localparam int SHOW_MAX   = 10;

  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_SEP} phase_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  class parse_scoreboard;
    result_t    expected_q[$];
    phase_t     phase;
    logic [3:0] high_digit;
    logic [6:0] bytes_seen;
    int         errors;

    function new();
      phase      = PH_IDLE;
      high_digit = '0;
      bytes_seen = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= SHOW_MAX) $display("%s", msg);
    endfunction

    // one character beat accepted: work out its result beat
    function void note_char(logic [CHAR_W-1:0] c, logic clr);
      result_t    r;
      logic [4:0] digit;  // bit 4 set when c is no lowercase hex digit
      r     = '0;
      digit = 5'h10;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        digit = {1'b0, 4'(c - CH_ZERO)};
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
        digit = {1'b0, 4'(c - CH_LOW_A + 8'd10)};
      end
      r.event_res = EV_REJECT;
      if (clr) begin
        phase       = PH_IDLE;
        bytes_seen  = '0;
        r.event_res = EV_CLEAR;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (c == CH_OPEN) begin
              phase       = PH_HIGH;
              r.event_res = EV_ECHO;
            end
          end
          PH_HIGH, PH_LOW: begin
            if (!digit[4]) begin
              if (bytes_seen >= MAX_MESSAGE_BYTES) begin
                phase       = PH_IDLE;
                bytes_seen  = '0;
                r.event_res = EV_OVER;
              end else if (phase == PH_HIGH) begin
                high_digit  = digit[3:0];
                phase       = PH_LOW;
                r.event_res = EV_ECHO;
              end else begin
                r.byte_value    = {high_digit, digit[3:0]};
                r.byte_position = bytes_seen[POS_W-1:0];
                if (bytes_seen == 0) r.event_res = EV_ADDR;
                else r.event_res = EV_DATA;
                phase      = PH_SEP;
                bytes_seen = bytes_seen + 7'd1;
              end
            end
          end
          default: begin
            if (c == CH_SPACE) begin
              phase       = PH_HIGH;
              r.event_res = EV_ECHO;
            end else if (c == CH_CLOSE) begin
              // address byte is not counted as data
              if (bytes_seen != 0) r.data_count = CNT_W'(bytes_seen - 7'd1);
              phase       = PH_IDLE;
              bytes_seen  = '0;
              r.event_res = EV_END;
            end
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data, logic [EVENT_W-1:0] ev);
      result_t want;
      result_t got;
      got.event_res     = event_t'(ev);
      got.byte_value    = data[7:0];
      got.byte_position = data[13:8];
      got.data_count    = data[19:14];
      if (expected_q.size() == 0) begin
        flag($sformatf("result beat with none expected: ev=%0d data=%h", ev, data));
        return;
      end
      want = expected_q.pop_front();
      if (got.event_res != want.event_res || got.byte_value != want.byte_value ||
          got.byte_position != want.byte_position || got.data_count != want.data_count ||
          data[OUT_DATA_W-1:20] != '0) begin
        flag($sformatf({"mismatch: exp ev=%0d val=%h pos=%0d cnt=%0d, ",
                        "got ev=%0d val=%h pos=%0d cnt=%0d pad=%h"},
                       want.event_res, want.byte_value, want.byte_position, want.data_count,
                       ev, got.byte_value, got.byte_position, got.data_count,
                       data[OUT_DATA_W-1:20]));
      end
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [EVENT_W-1:0]    m_axis_tuser;

  parse_scoreboard board = new();
  int              chars_sent = 0;
  int              burst_left = 0;
  int              cycles     = 0;
  logic [7:0]      stall_cnt  = '0;
  ready_mode_t     ready_mode = RDY_ALWAYS;

  bracketed_hex_byte_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sink stalls follow a mode that is redrawn at random whenever stall_cnt[5:0] is zero
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt[5:0] == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:    m_axis_tready <= (stall_cnt[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata, m_axis_tuser);
  end

  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + CHAR_W'(n);
    return CH_LOW_A + CHAR_W'(n) - 8'd10;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_char(input logic [CHAR_W-1:0] c, input logic clr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= clr;
    do @(posedge clk); while (!s_axis_tready);
    board.note_char(c, clr);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
  endtask

  task automatic send_message(input int nbytes, input bit closed);
    logic [7:0] b;
    put_char(CH_OPEN, 1'b0);
    for (int i = 0; i < nbytes; i++) begin
      if (i > 0) put_char(CH_SPACE, 1'b0);
      // occasional stray character inside a message
      if ($urandom_range(0, 99) < 5) put_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
      b = 8'($urandom_range(0, 255));
      put_char(hex_char(b[7:4]), 1'b0);
      put_char(hex_char(b[3:0]), 1'b0);
    end
    if (closed) put_char(CH_CLOSE, 1'b0);
  endtask

  initial begin
    int pick;
    int nbytes;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle rejects, bad digits, separators, clear mid-byte and idle
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    send_text("][A ]00x ff]");
    send_text("[5");
    put_char(CH_OPEN, 1'b1);
    send_text("7");
    put_char(8'hFF, 1'b1);

    while (chars_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // long messages, some of them past the buffer limit
        if ($urandom_range(0, 14) == 0) nbytes = $urandom_range(62, 70);
        else nbytes = $urandom_range(1, 8);
        send_message(nbytes, $urandom_range(0, 9) != 0);
      end else if (pick < 78) begin
        put_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          put_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
